// ===== rtl/shr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shr_pkg: shared types, constants and micro-programme
// Micro-op encodings, controller/datapath command struct, the Q.28 factor
// table and the per-phase micro-programme of the solid harmonics engine.
// ----------------------------------------------------------------------------
package shr_pkg;

  localparam logic signed [63:0] ONE_Q40 = 64'sd1 <<< 40;
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};

  typedef enum logic [2:0] {
    ST_IDLE, ST_R2, ST_DIAG, ST_OFFD, ST_UPW, ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    UOP_NOP, UOP_INIT, UOP_RD, UOP_LATC, UOP_LATP, UOP_MAC, UOP_RND, UOP_WR, UOP_EMIT
  } uop_kind_t;

  typedef enum logic [2:0] {A_X, A_Y, A_Z, A_R2, A_K} asel_t;

  typedef enum logic [3:0] {
    B_X, B_Y, B_Z, B_CRE, B_CIM, B_PRE, B_PIM, B_WRE, B_WIM
  } bsel_t;

  typedef enum logic [1:0] {SH16, SH28, SH40} shift_t;

  typedef enum logic [2:0] {D_R2, D_WRE, D_WIM, D_PRE, D_PIM, D_NRE, D_NIM} dst_t;

  typedef enum logic [2:0] {
    AD_ZERO, AD_LL, AD_LM, AD_L1M, AD_DIAG, AD_OFF, AD_UP, AD_EMIT
  } adsel_t;

  typedef enum logic [1:0] {K_DIAG, K_OFF, K_A, K_B} ksel_t;

  // one micro-programme entry
  typedef struct packed {
    uop_kind_t kind;
    asel_t     asel;
    bsel_t     bsel;
    logic      clr;
    logic      neg;
    shift_t    shift;
    dst_t      dst;
    logic      sat_en;
    adsel_t    adsel;
    ksel_t     ksel;
    logic      fin;
  } uop_t;

  // controller to datapath command
  typedef struct packed {
    uop_kind_t   kind;
    asel_t       asel;
    bsel_t       bsel;
    logic [1:0]  part;
    logic        clr;
    logic        neg;
    shift_t      shift;
    dst_t        dst;
    logic        sat_en;
    logic [31:0] kval;
    logic [2:0]  degree;
    logic [3:0]  slot;
    logic        conj;
    logic        flip;
    logic        last;
  } dp_cmd_t;

  typedef logic [31:0] ktab_t [0:255];

  // largest r with r*r*d <= n*2^56, i.e. floor(sqrt(floor(n*2^56/d)))
  function automatic logic [31:0] ksqrt(int unsigned n, int unsigned d);
    logic [127:0] num;
    logic [127:0] t;
    logic [127:0] sq;
    logic [31:0]  r;
    num = 128'(n) << 56;
    r   = '0;
    for (int b = 31; b >= 0; b--) begin
      t  = 128'(r) | (128'(1) << b);
      sq = t * t * 128'(d);
      if (sq <= num) r = t[31:0];
    end
    return r;
  endfunction

  // index {ksel, l, m}
  function automatic ktab_t build_ktab();
    ktab_t       tab;
    int unsigned n;
    int unsigned d;
    for (int k = 0; k < 4; k++) begin
      for (int l = 0; l < 8; l++) begin
        for (int m = 0; m < 8; m++) begin
          n = 0;
          d = 1;
          if (l <= 5 && m <= l) begin
            case (k)
              0: begin n = 2*l + 1; d = 2*l + 2; end
              1: begin n = 2*l + 1; d = 1; end
              2: begin n = (2*l + 1) * (2*l + 1); d = (l + m + 1) * (l - m + 1); end
              default: begin n = (l + m) * (l - m); d = (l + m + 1) * (l - m + 1); end
            endcase
          end
          tab[k*64 + l*8 + m] = ksqrt(n, d);
        end
      end
    end
    return tab;
  endfunction

  localparam ktab_t KTAB = build_ktab();

  localparam uop_t U_BASE = '{kind: UOP_NOP, asel: A_X, bsel: B_X, clr: 1'b0, neg: 1'b0,
                              shift: SH28, dst: D_WRE, sat_en: 1'b1, adsel: AD_ZERO,
                              ksel: K_DIAG, fin: 1'b0};

  function automatic uop_t u_op(uop_kind_t k, adsel_t ad, logic fin);
    uop_t u;
    u = U_BASE;
    u.kind  = k;
    u.adsel = ad;
    u.fin   = fin;
    return u;
  endfunction

  function automatic uop_t u_mac(asel_t a, bsel_t b, ksel_t ks, logic clr, logic neg);
    uop_t u;
    u = U_BASE;
    u.kind = UOP_MAC;
    u.asel = a;
    u.bsel = b;
    u.ksel = ks;
    u.clr  = clr;
    u.neg  = neg;
    return u;
  endfunction

  function automatic uop_t u_rnd(shift_t s, dst_t d, logic sat_en, logic fin);
    uop_t u;
    u = U_BASE;
    u.kind   = UOP_RND;
    u.shift  = s;
    u.dst    = d;
    u.sat_en = sat_en;
    u.fin    = fin;
    return u;
  endfunction

  // micro-programme; a MAC entry steps through all four partial products
  function automatic uop_t prog_f(state_t st, logic [4:0] op);
    uop_t u;
    u = U_BASE;
    case (st)
      ST_R2: begin
        case (op)
          5'd0: u = u_op(UOP_INIT, AD_ZERO, 1'b0);
          5'd1: u = u_mac(A_X, B_X, K_DIAG, 1'b1, 1'b0);
          5'd2: u = u_mac(A_Y, B_Y, K_DIAG, 1'b0, 1'b0);
          5'd3: u = u_mac(A_Z, B_Z, K_DIAG, 1'b0, 1'b0);
          default: u = u_rnd(SH16, D_R2, 1'b0, 1'b1);
        endcase
      end
      ST_DIAG: begin
        case (op)
          5'd0:  u = u_op(UOP_RD, AD_LL, 1'b0);
          5'd1:  u = u_op(UOP_LATC, AD_LL, 1'b0);
          5'd2:  u = u_mac(A_X, B_CRE, K_DIAG, 1'b1, 1'b0);
          5'd3:  u = u_mac(A_Y, B_CIM, K_DIAG, 1'b0, 1'b1);
          5'd4:  u = u_rnd(SH28, D_WRE, 1'b1, 1'b0);
          5'd5:  u = u_mac(A_X, B_CIM, K_DIAG, 1'b1, 1'b0);
          5'd6:  u = u_mac(A_Y, B_CRE, K_DIAG, 1'b0, 1'b0);
          5'd7:  u = u_rnd(SH28, D_WIM, 1'b1, 1'b0);
          5'd8:  u = u_mac(A_K, B_WRE, K_DIAG, 1'b1, 1'b1);
          5'd9:  u = u_rnd(SH28, D_NRE, 1'b1, 1'b0);
          5'd10: u = u_mac(A_K, B_WIM, K_DIAG, 1'b1, 1'b1);
          5'd11: u = u_rnd(SH28, D_NIM, 1'b1, 1'b0);
          default: u = u_op(UOP_WR, AD_DIAG, 1'b1);
        endcase
      end
      ST_OFFD: begin
        case (op)
          5'd0: u = u_op(UOP_RD, AD_LL, 1'b0);
          5'd1: u = u_op(UOP_LATC, AD_LL, 1'b0);
          5'd2: u = u_mac(A_Z, B_CRE, K_OFF, 1'b1, 1'b0);
          5'd3: u = u_rnd(SH28, D_WRE, 1'b1, 1'b0);
          5'd4: u = u_mac(A_Z, B_CIM, K_OFF, 1'b1, 1'b0);
          5'd5: u = u_rnd(SH28, D_WIM, 1'b1, 1'b0);
          5'd6: u = u_mac(A_K, B_WRE, K_OFF, 1'b1, 1'b0);
          5'd7: u = u_rnd(SH28, D_NRE, 1'b1, 1'b0);
          5'd8: u = u_mac(A_K, B_WIM, K_OFF, 1'b1, 1'b0);
          5'd9: u = u_rnd(SH28, D_NIM, 1'b1, 1'b0);
          default: u = u_op(UOP_WR, AD_OFF, 1'b1);
        endcase
      end
      ST_UPW: begin
        case (op)
          5'd0:  u = u_op(UOP_RD, AD_LM, 1'b0);
          5'd1:  u = u_op(UOP_LATC, AD_LM, 1'b0);
          5'd2:  u = u_op(UOP_RD, AD_L1M, 1'b0);
          5'd3:  u = u_op(UOP_LATP, AD_L1M, 1'b0);
          5'd4:  u = u_mac(A_Z, B_CRE, K_A, 1'b1, 1'b0);
          5'd5:  u = u_rnd(SH28, D_WRE, 1'b1, 1'b0);
          5'd6:  u = u_mac(A_Z, B_CIM, K_A, 1'b1, 1'b0);
          5'd7:  u = u_rnd(SH28, D_WIM, 1'b1, 1'b0);
          5'd8:  u = u_mac(A_R2, B_PRE, K_A, 1'b1, 1'b0);
          5'd9:  u = u_rnd(SH40, D_PRE, 1'b1, 1'b0);
          5'd10: u = u_mac(A_R2, B_PIM, K_A, 1'b1, 1'b0);
          5'd11: u = u_rnd(SH40, D_PIM, 1'b1, 1'b0);
          5'd12: u = u_mac(A_K, B_WRE, K_A, 1'b1, 1'b0);
          5'd13: u = u_mac(A_K, B_PRE, K_B, 1'b0, 1'b1);
          5'd14: u = u_rnd(SH28, D_NRE, 1'b1, 1'b0);
          5'd15: u = u_mac(A_K, B_WIM, K_A, 1'b1, 1'b0);
          5'd16: u = u_mac(A_K, B_PIM, K_B, 1'b0, 1'b1);
          5'd17: u = u_rnd(SH28, D_NIM, 1'b1, 1'b0);
          default: u = u_op(UOP_WR, AD_UP, 1'b1);
        endcase
      end
      ST_EMIT: begin
        case (op)
          5'd0: u = u_op(UOP_RD, AD_EMIT, 1'b0);
          5'd1: u = u_op(UOP_LATC, AD_EMIT, 1'b0);
          default: u = u_op(UOP_EMIT, AD_EMIT, 1'b1);
        endcase
      end
      default: u = U_BASE;
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/solid_harmonics_recurrence.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// solid_harmonics_recurrence: regular solid harmonics of a displacement
// Top level: configuration register, sequencer and shared MAC datapath.
// ----------------------------------------------------------------------------
// A vector is taken when start is high and busy is low; busy then stays high
// until the last coefficient has been issued. Coefficients C[l][m] for
// l = 0..L (L = max_degree, clipped to DEGREE_LIMIT) come out in array order
// with valid high for exactly one cycle each, last set on the final one; the
// receiver cannot stall, so every valid cycle is a transfer. All products
// share one 33x33 multiplier, four partials per 64-bit product. max_degree
// is written through cfg_we/cfg_data; the user must write it only while idle,
// as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module solid_harmonics_recurrence import shr_pkg::*; #(
  parameter int DEGREE_LIMIT = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_data,
  output logic               valid,
  output logic [2:0]         degree,
  output logic [3:0]         slot,
  output logic signed [63:0] real_part,
  output logic signed [63:0] imag_part,
  output logic               saturated,
  output logic               last
);

  localparam int DEPTH = (DEGREE_LIMIT + 1) * (DEGREE_LIMIT + 1);
  localparam int AW    = $clog2(DEPTH);

  dp_cmd_t       cmd;
  logic [AW-1:0] addr;
  logic          load;

  shr_controller #(
    .LIMIT (DEGREE_LIMIT),
    .AW    (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .busy     (busy),
    .load     (load),
    .cmd      (cmd),
    .addr     (addr)
  );

  shr_datapath #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .cmd       (cmd),
    .addr      (addr),
    .valid     (valid),
    .degree    (degree),
    .slot      (slot),
    .real_part (real_part),
    .imag_part (imag_part),
    .saturated (saturated),
    .last      (last)
  );

endmodule

// ===== rtl/shr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shr_datapath: coefficient store and shared multiply-accumulate unit
// One 33x33 signed multiplier builds 64x64 products from four partials into
// a 128-bit accumulator; a rounding/saturation stage and the result registers.
// ----------------------------------------------------------------------------
module shr_datapath import shr_pkg::*; #(
  parameter int DEPTH = 25,
  parameter int AW    = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  dp_cmd_t            cmd,
  input  logic [AW-1:0]      addr,
  output logic               valid,
  output logic [2:0]         degree,
  output logic [3:0]         slot,
  output logic signed [63:0] real_part,
  output logic signed [63:0] imag_part,
  output logic               saturated,
  output logic               last
);

  logic signed [63:0] mem_re [0:DEPTH-1];
  logic signed [63:0] mem_im [0:DEPTH-1];
  logic               mem_sf [0:DEPTH-1];
  logic signed [63:0] rd_re, rd_im;
  logic               rd_sf;

  logic signed [31:0] x, y, z;
  logic signed [63:0] r2, cre, cim, pre, pim, wre, wim, nre, nim;
  logic               sf;
  logic signed [127:0] acc;

  logic signed [63:0]  a_op, b_op;
  logic signed [32:0]  a_ch, b_ch;
  logic signed [65:0]  prod;
  logic signed [127:0] term, acc_next;
  logic signed [127:0] rnd_sum, rnd_shr;
  logic [6:0]          shamt;
  logic signed [63:0]  rnd_val;
  logic                rnd_sat;

  logic signed [63:0] im1, re_o, im_o;
  logic               s_o;

  always_ff @(posedge clk) begin
    if (cmd.kind == UOP_INIT) begin
      mem_re[addr] <= ONE_Q40;
      mem_im[addr] <= '0;
      mem_sf[addr] <= 1'b0;
    end else if (cmd.kind == UOP_WR) begin
      mem_re[addr] <= nre;
      mem_im[addr] <= nim;
      mem_sf[addr] <= sf;
    end
    rd_re <= mem_re[addr];
    rd_im <= mem_im[addr];
    rd_sf <= mem_sf[addr];
  end

  always_comb begin
    case (cmd.asel)
      A_X:     a_op = 64'(x);
      A_Y:     a_op = 64'(y);
      A_Z:     a_op = 64'(z);
      A_R2:    a_op = r2;
      A_K:     a_op = {32'd0, cmd.kval};
      default: a_op = '0;
    endcase
    case (cmd.bsel)
      B_X:     b_op = 64'(x);
      B_Y:     b_op = 64'(y);
      B_Z:     b_op = 64'(z);
      B_CRE:   b_op = cre;
      B_CIM:   b_op = cim;
      B_PRE:   b_op = pre;
      B_PIM:   b_op = pim;
      B_WRE:   b_op = wre;
      B_WIM:   b_op = wim;
      default: b_op = '0;
    endcase
    a_ch = cmd.part[1] ? {a_op[63], a_op[63:32]} : {1'b0, a_op[31:0]};
    b_ch = cmd.part[0] ? {b_op[63], b_op[63:32]} : {1'b0, b_op[31:0]};
    prod = a_ch * b_ch;
    case (cmd.part)
      2'd0:    term = 128'(prod);
      2'd3:    term = 128'(prod) <<< 64;
      default: term = 128'(prod) <<< 32;
    endcase
    if (cmd.neg) term = -term;
    acc_next = (cmd.clr && cmd.part == 2'd0) ? term : acc + term;
  end

  // round half up, arithmetic shift, clip to 64 bits
  always_comb begin
    case (cmd.shift)
      SH16:    shamt = 7'd16;
      SH40:    shamt = 7'd40;
      default: shamt = 7'd28;
    endcase
    rnd_sum = acc + (128'sd1 <<< (shamt - 7'd1));
    rnd_shr = rnd_sum >>> shamt;
    rnd_sat = !((&rnd_shr[127:63]) || !(|rnd_shr[127:63]));
    if (rnd_sat) rnd_val = rnd_shr[127] ? S64_MIN : S64_MAX;
    else         rnd_val = rnd_shr[63:0];
  end

  // negative orders: conjugate, then negate both parts for odd m
  always_comb begin
    s_o  = sf;
    im1  = cim;
    re_o = cre;
    if (cmd.conj) begin
      if (cim == S64_MIN) begin
        im1 = S64_MAX;
        s_o = 1'b1;
      end else begin
        im1 = -cim;
      end
    end
    im_o = im1;
    if (cmd.flip) begin
      if (cre == S64_MIN) begin
        re_o = S64_MAX;
        s_o  = 1'b1;
      end else begin
        re_o = -cre;
      end
      if (im1 == S64_MIN) begin
        im_o = S64_MAX;
        s_o  = 1'b1;
      end else begin
        im_o = -im1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x <= pos_x;
      y <= pos_y;
      z <= pos_z;
    end
    case (cmd.kind)
      UOP_LATC: begin
        cre <= rd_re;
        cim <= rd_im;
        sf  <= rd_sf;
      end
      UOP_LATP: begin
        pre <= rd_re;
        pim <= rd_im;
        sf  <= sf | rd_sf;
      end
      UOP_MAC: acc <= acc_next;
      UOP_RND: begin
        if (cmd.sat_en && rnd_sat) sf <= 1'b1;
        case (cmd.dst)
          D_R2:    r2  <= rnd_val;
          D_WRE:   wre <= rnd_val;
          D_WIM:   wim <= rnd_val;
          D_PRE:   pre <= rnd_val;
          D_PIM:   pim <= rnd_val;
          D_NRE:   nre <= rnd_val;
          D_NIM:   nim <= rnd_val;
          default: nim <= rnd_val;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= (cmd.kind == UOP_EMIT);
    end
    if (cmd.kind == UOP_EMIT) begin
      degree    <= cmd.degree;
      slot      <= cmd.slot;
      real_part <= re_o;
      imag_part <= im_o;
      saturated <= s_o;
      last      <= cmd.last;
    end
  end

endmodule

// ===== rtl/shr_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shr_controller: sequencer for the recurrences
// Walks the phases (r2, diagonal, off-diagonal, upward, output), steps the
// micro-programme and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module shr_controller import shr_pkg::*; #(
  parameter int LIMIT = 4,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_data,
  output logic          busy,
  output logic          load,
  output dp_cmd_t       cmd,
  output logic [AW-1:0] addr
);

  localparam int ROW = LIMIT + 1;
  localparam logic [2:0] LIM3 = 3'(LIMIT);

  state_t     state, state_next;
  logic [4:0] op, op_next;
  logic [1:0] part, part_next;
  logic [2:0] l, l_next, m, m_next, lmax, lmax_next, max_degree;
  logic [3:0] p, p_next;

  uop_t       u;
  logic [3:0] pd;
  logic [2:0] em, al, am, kl, km;
  logic       conj, step_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      op         <= '0;
      part       <= '0;
      l          <= '0;
      m          <= '0;
      p          <= '0;
      lmax       <= '0;
      max_degree <= 3'd4;
    end else begin
      state <= state_next;
      op    <= op_next;
      part  <= part_next;
      l     <= l_next;
      m     <= m_next;
      p     <= p_next;
      lmax  <= lmax_next;
      if (cfg_we) max_degree <= cfg_data;
    end
  end

  always_comb begin
    u    = prog_f(state, op);
    pd   = p - {1'b0, l};
    conj = (p > {1'b0, l});
    em   = conj ? pd[2:0] : p[2:0];
    busy = (state != ST_IDLE);
    load = start && !busy;

    case (u.adsel)
      AD_LL:   begin al = l;        am = l;        end
      AD_LM:   begin al = l;        am = m;        end
      AD_L1M:  begin al = l - 3'd1; am = m;        end
      AD_DIAG: begin al = l + 3'd1; am = l + 3'd1; end
      AD_OFF:  begin al = l + 3'd1; am = l;        end
      AD_UP:   begin al = l + 3'd1; am = m;        end
      AD_EMIT: begin al = l;        am = em;       end
      default: begin al = '0;       am = '0;       end
    endcase
    addr = AW'(int'(al) * ROW + int'(am));

    kl = l;
    km = m;
    cmd.kind   = busy ? u.kind : UOP_NOP;
    cmd.asel   = u.asel;
    cmd.bsel   = u.bsel;
    cmd.part   = part;
    cmd.clr    = u.clr;
    cmd.neg    = u.neg;
    cmd.shift  = u.shift;
    cmd.dst    = u.dst;
    cmd.sat_en = u.sat_en;
    cmd.kval   = KTAB[{u.ksel, kl, km}];
    cmd.degree = l;
    cmd.slot   = p;
    cmd.conj   = conj;
    cmd.flip   = conj && em[0];
    cmd.last   = (l == lmax) && (p == {l, 1'b0});

    state_next = state;
    op_next    = op;
    part_next  = part;
    l_next     = l;
    m_next     = m;
    p_next     = p;
    lmax_next  = lmax;
    step_done  = (u.kind != UOP_MAC) || (part == 2'd3);

    if (state == ST_IDLE) begin
      if (start) begin
        state_next = ST_R2;
        op_next    = '0;
        part_next  = '0;
        lmax_next  = (max_degree > LIM3) ? LIM3 : max_degree;
      end
    end else if (!step_done) begin
      part_next = part + 2'd1;
    end else begin
      part_next = '0;
      if (!u.fin) begin
        op_next = op + 5'd1;
      end else begin
        op_next = '0;
        case (state)
          ST_R2: begin
            l_next = '0;
            p_next = '0;
            state_next = (lmax == 3'd0) ? ST_EMIT : ST_DIAG;
          end
          ST_DIAG: begin
            if (l + 3'd1 == lmax) begin
              state_next = ST_OFFD;
              l_next     = '0;
            end else begin
              l_next = l + 3'd1;
            end
          end
          ST_OFFD: begin
            if (l + 3'd1 == lmax) begin
              m_next = '0;
              p_next = '0;
              if (lmax >= 3'd2) begin
                state_next = ST_UPW;
                l_next     = 3'd1;
              end else begin
                state_next = ST_EMIT;
                l_next     = '0;
              end
            end else begin
              l_next = l + 3'd1;
            end
          end
          ST_UPW: begin
            if (m + 3'd1 == l) begin
              m_next = '0;
              if (l + 3'd1 == lmax) begin
                state_next = ST_EMIT;
                l_next     = '0;
                p_next     = '0;
              end else begin
                l_next = l + 3'd1;
              end
            end else begin
              m_next = m + 3'd1;
            end
          end
          ST_EMIT: begin
            if (p == {l, 1'b0}) begin
              p_next = '0;
              if (l == lmax) state_next = ST_IDLE;
              else           l_next = l + 3'd1;
            end else begin
              p_next = p + 4'd1;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
    end
  end

endmodule

// ===== rtl/shr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shr_checker: port-level checks for solid_harmonics_recurrence
// Watches the command handshake and the result stream over time.
// ----------------------------------------------------------------------------
module shr_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       valid,
  input logic       last,
  input logic [2:0] degree,
  input logic [3:0] slot
);

  // a taken vector keeps the block busy
  assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("busy did not rise after a start transfer");

  // results other than the final one arrive while busy
  assert property (@(posedge clk) disable iff (rst) valid && !last |-> busy)
    else $error("result transfer outside a busy period");

  // the final result ends the busy period
  assert property (@(posedge clk) disable iff (rst) valid && last |-> !busy)
    else $error("busy still high with the final result");

  assert property (@(posedge clk) disable iff (rst) valid && last |=> !valid)
    else $error("result after the final one");

  assert property (@(posedge clk) disable iff (rst) valid |-> slot <= {degree, 1'b0})
    else $error("slot beyond 2*degree");

endmodule

bind solid_harmonics_recurrence shr_checker u_shr_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .valid  (valid),
  .last   (last),
  .degree (degree),
  .slot   (slot)
);
